// ----- hdl/ptrie_pkg.sv -----
// Package for the prefix trie engine: item field widths, mode codes and
// sequencer states. No dependencies.
package ptrie_pkg;

    localparam int MODE_W   = 2;
    localparam int LETTER_W = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_PREFIX = 2'd2,
        MODE_UNUSED = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_FINISH
    } t_state;

endpackage

// ----- hdl/ptrie_in_if.sv -----
// Input channel of the prefix trie engine: one letter item per handshake.
// Depends on ptrie_pkg.
interface ptrie_in_if;
    import ptrie_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [LETTER_W-1:0] letter_code;
    logic                no_letter;
    logic                last_letter;

    modport source (output valid, mode, letter_code, no_letter, last_letter, input ready);
    modport sink   (input valid, mode, letter_code, no_letter, last_letter, output ready);
endinterface

// ----- hdl/ptrie_out_if.sv -----
// Output channel of the prefix trie engine: one result item per word.
// No dependencies.
interface ptrie_out_if;
    logic valid;
    logic ready;
    logic found;
    logic pool_full;

    modport source (output valid, found, pool_full, input ready);
    modport sink   (input valid, found, pool_full, output ready);
endinterface

// ----- hdl/prefix_trie_engine.sv -----
// Prefix trie engine top level: node store memory and the walk sequencer.
// Depends on ptrie_pkg, ptrie_in_if and ptrie_out_if.
//
// Words are stored in a trie held in one synchronous memory, one row per node:
// ALPHABET child indexes plus the word-end flag. After reset the block runs a
// clearing pass, one row per cycle, with i_item.ready low. Each letter item
// then has its cursor row read in the accept cycle, and the walk step
// (and any new-node write) happens in the next one. The item that carries
// last_letter adds a read of the row of the node the walk ended on, and
// waits in ST_FINISH while the result register is still waiting to be taken.
// The block takes no new letter item until the last one is through.
module prefix_trie_engine #(
    parameter int NODE_COUNT = 1024,
    parameter int ALPHABET   = 26
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptrie_in_if.sink    i_item,
    ptrie_out_if.source o_result
);
    import ptrie_pkg::*;

    localparam int NW    = $clog2(NODE_COUNT);
    localparam int LW    = $clog2(ALPHABET);
    localparam int CW    = ((LW > LETTER_W) ? LW : LETTER_W) + 1;
    localparam int END_B = ALPHABET * NW;
    localparam int ROW_W = END_B + 1;

    logic [ROW_W-1:0] mem [NODE_COUNT];

    t_state            r_state,     n_state;
    logic [NW-1:0]     r_clr_addr,  n_clr_addr;
    logic [NW:0]       r_next_free, n_next_free;
    logic [NW-1:0]     r_cursor,    n_cursor;
    logic              r_miss,      n_miss;
    logic              r_ovf,       n_ovf;
    t_mode             r_mode,      n_mode;
    logic [LETTER_W-1:0] r_letter,  n_letter;
    logic              r_no_letter, n_no_letter;
    logic              r_last,      n_last;
    logic              r_out_valid, n_out_valid;
    logic              r_found,     n_found;
    logic              r_pool_full, n_pool_full;
    logic [ROW_W-1:0]  r_rd_row;

    logic              mem_we;
    logic              mem_re;
    logic [NW-1:0]     mem_wa;
    logic [NW-1:0]     mem_ra;
    logic [ROW_W-1:0]  mem_wd;

    logic [CW-1:0]     letter_ext;
    logic              in_range;
    logic [LW-1:0]     idx;
    logic [NW-1:0]     child;
    logic [ROW_W-1:0]  alloc_row;
    logic              stuck;

    assign letter_ext = CW'(r_letter);
    assign in_range   = letter_ext < CW'(ALPHABET);
    assign idx        = LW'(letter_ext);
    assign child      = r_rd_row[int'(idx)*NW +: NW];
    assign stuck      = r_miss || r_ovf;

    always_comb begin
        alloc_row = r_rd_row;
        alloc_row[int'(idx)*NW +: NW] = r_next_free[NW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_row <= mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_next_free <= (NW+1)'(1);
            r_cursor    <= '0;
            r_miss      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_next_free <= n_next_free;
            r_cursor    <= n_cursor;
            r_miss      <= n_miss;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_letter    <= n_letter;
        r_no_letter <= n_no_letter;
        r_last      <= n_last;
        r_found     <= n_found;
        r_pool_full <= n_pool_full;
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_next_free = r_next_free;
        n_cursor    = r_cursor;
        n_miss      = r_miss;
        n_ovf       = r_ovf;
        n_mode      = r_mode;
        n_letter    = r_letter;
        n_no_letter = r_no_letter;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_found     = r_found;
        n_pool_full = r_pool_full;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_wa      = r_cursor;
        mem_ra      = r_cursor;
        mem_wd      = r_rd_row;
        i_item.ready = 1'b0;

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_wa     = r_clr_addr;
                mem_wd     = '0;
                n_clr_addr = r_clr_addr + NW'(1);
                if (r_clr_addr == NW'(NODE_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                i_item.ready = 1'b1;
                if (i_item.valid) begin
                    n_mode      = t_mode'(i_item.mode);
                    n_letter    = i_item.letter_code;
                    n_no_letter = i_item.no_letter;
                    n_last      = i_item.last_letter;
                    mem_re      = 1'b1;
                    mem_ra      = r_cursor;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!r_no_letter && !stuck) begin
                    if (!in_range) begin
                        n_miss = 1'b1;
                    end else if (child == '0) begin
                        if (r_mode != MODE_INSERT) begin
                            n_miss = 1'b1;
                        end else if (r_next_free == (NW+1)'(NODE_COUNT)) begin
                            n_ovf = 1'b1;
                        end else begin
                            mem_we      = 1'b1;
                            mem_wa      = r_cursor;
                            mem_wd      = alloc_row;
                            n_cursor    = r_next_free[NW-1:0];
                            n_next_free = r_next_free + (NW+1)'(1);
                        end
                    end else begin
                        n_cursor = child;
                    end
                end
                if (r_last) begin
                    mem_re  = 1'b1;
                    mem_ra  = n_cursor;
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_pool_full = r_ovf;
                    n_found     = 1'b0;
                    if (!stuck) begin
                        case (r_mode)
                            MODE_INSERT: begin
                                n_found          = 1'b1;
                                mem_we           = 1'b1;
                                mem_wa           = r_cursor;
                                mem_wd           = r_rd_row;
                                mem_wd[END_B]    = 1'b1;
                            end
                            MODE_SEARCH: n_found = r_rd_row[END_B];
                            MODE_PREFIX: n_found = 1'b1;
                            default:     n_found = 1'b0;
                        endcase
                    end
                    n_cursor = '0;
                    n_miss   = 1'b0;
                    n_ovf    = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.found     = r_found;
    assign o_result.pool_full = r_pool_full;

endmodule
